[hw/rtl/mcpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mcpg_pkg;

  localparam int OCTANT_DEPTH_DEF = 256;
  localparam int RADIUS_W = 9;
  localparam int CENTER_W = 10;
  localparam int POINT_W = 12;
  localparam int DEC_W = 12;
  localparam int SEG_W = 3;
  localparam int STEP_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = 9'd355;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 9'd200;
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 10'd600;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 10'd500;
  localparam logic [SEG_W-1:0] SEG_LAST = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd2;

  localparam logic [STEP_W-1:0] S_WAIT = 3'd0;
  localparam logic [STEP_W-1:0] S_DISPATCH = 3'd1;
  localparam logic [STEP_W-1:0] S_INIT = 3'd2;
  localparam logic [STEP_W-1:0] S_WALK = 3'd3;
  localparam logic [STEP_W-1:0] S_FINISH = 3'd4;
  localparam logic [STEP_W-1:0] S_READ = 3'd5;
  localparam logic [STEP_W-1:0] S_EMIT = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_WALK,
    OP_FINISH,
    OP_READ,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_ACCEPT,
    C_RESTART,
    C_WALK_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic              in_ready;
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] br_addr;
    logic [STEP_W-1:0] seq_addr;
  } ctrl_word_t;

  typedef struct packed {
    logic in_accept;
    logic restart;
    logic walk_more;
    logic out_busy;
  } dp_status_t;

  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{in_ready: 1'b0, op: OP_NOP, cond: C_NONE, br_addr: S_WAIT, seq_addr: S_WAIT};
    case (step)
      S_WAIT: begin
        cw = '{in_ready: 1'b1, op: OP_NOP, cond: C_NO_ACCEPT,
               br_addr: S_WAIT, seq_addr: S_DISPATCH};
      end
      S_DISPATCH: begin
        cw = '{in_ready: 1'b0, op: OP_NOP, cond: C_RESTART,
               br_addr: S_INIT, seq_addr: S_READ};
      end
      S_INIT: begin
        cw = '{in_ready: 1'b0, op: OP_INIT, cond: C_NONE,
               br_addr: S_WALK, seq_addr: S_WALK};
      end
      S_WALK: begin
        cw = '{in_ready: 1'b0, op: OP_WALK, cond: C_WALK_MORE,
               br_addr: S_WALK, seq_addr: S_FINISH};
      end
      S_FINISH: begin
        cw = '{in_ready: 1'b0, op: OP_FINISH, cond: C_NONE,
               br_addr: S_READ, seq_addr: S_READ};
      end
      S_READ: begin
        cw = '{in_ready: 1'b0, op: OP_READ, cond: C_NONE,
               br_addr: S_EMIT, seq_addr: S_EMIT};
      end
      S_EMIT: begin
        cw = '{in_ready: 1'b0, op: OP_EMIT, cond: C_OUT_BUSY,
               br_addr: S_EMIT, seq_addr: S_WAIT};
      end
      default: begin
        cw = '{in_ready: 1'b0, op: OP_NOP, cond: C_NONE,
               br_addr: S_WAIT, seq_addr: S_WAIT};
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mcpg_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mcpg_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mcpg_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module mcpg_seq
  import mcpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_status_t status,
  output ctrl_word_t      cw
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              taken;

  assign cw = ucode_rom(step);

  always_comb begin
    case (cw.cond)
      C_NONE:      taken = 1'b0;
      C_NO_ACCEPT: taken = !status.in_accept;
      C_RESTART:   taken = status.restart;
      C_WALK_MORE: taken = status.walk_more;
      C_OUT_BUSY:  taken = status.out_busy;
      default:     taken = 1'b0;
    endcase
    step_next = taken ? cw.br_addr : cw.seq_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mcpg_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module mcpg_dp
  import mcpg_pkg::*;
#(
  parameter int OCTANT_DEPTH = OCTANT_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ctrl_word_t                cw,
  input  wire logic                      in_accept,
  input  wire logic                      restart,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                      out_stall,
  output dp_status_t                     status,
  output logic                           out_valid,
  output logic signed [POINT_W-1:0]      point_x,
  output logic signed [POINT_W-1:0]      point_y,
  output logic                           last_point
);

  localparam int ADDR_W = $clog2(OCTANT_DEPTH);
  localparam int CNT_W = $clog2(OCTANT_DEPTH + 1);

  logic [RADIUS_W-1:0]     radius;
  logic [CENTER_W-1:0]     center_x;
  logic [CENTER_W-1:0]     center_y;
  logic                    restart_q;

  logic [RADIUS_W-1:0]     wx;
  logic [RADIUS_W-1:0]     wy;
  logic signed [DEC_W-1:0] dec;
  logic [CNT_W-1:0]        count;
  logic                    octant_valid;
  logic [SEG_W-1:0]        seg;
  logic [ADDR_W-1:0]       pos;
  logic [ADDR_W-1:0]       cur;

  logic [RADIUS_W-1:0]     r_clamp;
  logic                    walk_more;
  logic [RADIUS_W-1:0]     wx_next;
  logic [RADIUS_W-1:0]     wy_next;
  logic signed [DEC_W-1:0] dec_next;
  logic signed [DEC_W-1:0] xs;
  logic signed [DEC_W-1:0] ys;

  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [RADIUS_W-1:0]     wr_x;
  logic [RADIUS_W-1:0]     wr_y;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [RADIUS_W-1:0]     rd_x;
  logic [RADIUS_W-1:0]     rd_y;

  logic [CNT_W-1:0]        n_m1;
  logic [ADDR_W-1:0]       c_sel;
  logic [ADDR_W-1:0]       m_sel;
  logic                    at_end;
  logic                    out_busy;
  logic                    emit;
  logic [POINT_W-1:0]      cxe;
  logic [POINT_W-1:0]      cye;
  logic [POINT_W-1:0]      rxe;
  logic [POINT_W-1:0]      rye;
  logic [POINT_W-1:0]      px_next;
  logic [POINT_W-1:0]      py_next;

  assign r_clamp = (radius > RADIUS_MAX) ? RADIUS_MAX : radius;
  assign walk_more = wy > wx;

  assign xs = DEC_W'(wx);
  assign ys = DEC_W'(wy);

  always_comb begin
    wx_next = wx + 1'b1;
    if (dec < 0) begin
      wy_next = wy;
      dec_next = dec + (xs <<< 1) + DEC_W'(3);
    end else begin
      wy_next = wy - 1'b1;
      dec_next = dec + ((xs - ys) <<< 1) + DEC_W'(5);
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_x = wx_next;
    wr_y = wy_next;
    if (cw.op == OP_INIT) begin
      wr_en = 1'b1;
      wr_x = '0;
      wr_y = r_clamp;
    end else if (cw.op == OP_WALK) begin
      wr_en = walk_more && (count < CNT_W'(OCTANT_DEPTH));
      wr_addr = count[ADDR_W-1:0];
    end
  end

  assign n_m1 = count - 1'b1;
  assign c_sel = (CNT_W'(pos) > n_m1) ? n_m1[ADDR_W-1:0] : pos;
  assign m_sel = ADDR_W'(n_m1 - CNT_W'(c_sel));
  assign rd_en = (cw.op == OP_READ);
  assign rd_addr = seg[0] ? c_sel : m_sel;

  mcpg_ram #(
    .WIDTH(RADIUS_W),
    .DEPTH(OCTANT_DEPTH)
  ) u_x_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_x),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_x)
  );

  mcpg_ram #(
    .WIDTH(RADIUS_W),
    .DEPTH(OCTANT_DEPTH)
  ) u_y_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_y),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_y)
  );

  assign at_end = (CNT_W'(cur) == n_m1);
  assign out_busy = out_valid && out_stall;
  assign emit = (cw.op == OP_EMIT) && !out_busy;

  assign cxe = POINT_W'(center_x);
  assign cye = POINT_W'(center_y);
  assign rxe = POINT_W'(rd_x);
  assign rye = POINT_W'(rd_y);

  always_comb begin
    case (seg)
      3'd0: begin
        px_next = cxe - rxe;
        py_next = cye - rye;
      end
      3'd1: begin
        px_next = cxe + rxe;
        py_next = cye - rye;
      end
      3'd2: begin
        px_next = cxe + rye;
        py_next = cye - rxe;
      end
      3'd3: begin
        px_next = cxe + rye;
        py_next = cye + rxe;
      end
      3'd4: begin
        px_next = cxe + rxe;
        py_next = cye + rye;
      end
      default: begin
        px_next = cxe - rxe;
        py_next = cye + rye;
      end
    endcase
  end

  assign status = '{in_accept: in_accept, restart: restart_q,
                    walk_more: walk_more, out_busy: out_busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RST;
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
      restart_q <= 1'b0;
      count <= '0;
      octant_valid <= 1'b0;
      seg <= '0;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS:   radius <= cfg_data[RADIUS_W-1:0];
          REG_CENTER_X: center_x <= cfg_data[CENTER_W-1:0];
          REG_CENTER_Y: center_y <= cfg_data[CENTER_W-1:0];
          default:      ;
        endcase
      end
      if (in_accept) begin
        restart_q <= restart;
      end
      case (cw.op)
        OP_INIT: begin
          wx <= '0;
          wy <= r_clamp;
          dec <= DEC_W'(1) - DEC_W'(r_clamp);
          count <= CNT_W'(1);
        end
        OP_WALK: begin
          if (walk_more) begin
            wx <= wx_next;
            wy <= wy_next;
            dec <= dec_next;
            if (count < CNT_W'(OCTANT_DEPTH)) begin
              count <= count + 1'b1;
            end
          end
        end
        OP_FINISH: begin
          seg <= '0;
          pos <= '0;
          octant_valid <= 1'b1;
        end
        OP_READ: begin
          cur <= c_sel;
        end
        default: ;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
        if (octant_valid) begin
          point_x <= px_next;
          point_y <= py_next;
          last_point <= (seg >= SEG_LAST) && at_end;
          if (at_end) begin
            pos <= '0;
            seg <= (seg >= SEG_LAST) ? '0 : seg + 1'b1;
          end else begin
            pos <= cur + 1'b1;
          end
        end else begin
          point_x <= '0;
          point_y <= '0;
          last_point <= 1'b0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/midpoint_circle_point_generator_core.sv]
// Midpoint circle point generator.
// Input channel (in_valid, in_stall, restart): each transfer asks for one
// point. With restart set, the octant is first recomputed from the radius
// register, one walk step per cycle; the point sequence then starts over.
// Otherwise the next point of the six mirrored segments is produced, wrapping
// after the one with last_point.
// Output channel (out_valid, out_stall, point_x, point_y, last_point): one
// transfer per input transfer. After its input transfer, a point passes the
// dispatch, read and emit steps (with init, walk and finish first on a
// restart). Inputs are taken only in the wait step, so each point runs the
// control program steps (wait, dispatch, read, emit) before the next is taken.
// While out_stall holds the finished point, the next input is still taken
// but its point waits in the emit step until the output register is free.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is the radius, 1 and 2 the center coordinates.
// Reset restores radius 200 and center (600, 500); points read as zero and
// the sequence does not advance until the first restart.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_point_generator_core
  import mcpg_pkg::*;
#(
  parameter int OCTANT_DEPTH = OCTANT_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  restart,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [POINT_W-1:0]  point_x,
  output logic signed [POINT_W-1:0]  point_y,
  output logic                       last_point,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_word_t cw;
  dp_status_t status;
  logic       in_accept;

  assign in_stall = !cw.in_ready;
  assign in_accept = in_valid && cw.in_ready;
  assign cfg_ready = 1'b1;

  mcpg_seq u_seq (
    .clk(clk),
    .rst(rst),
    .status(status),
    .cw(cw)
  );

  mcpg_dp #(
    .OCTANT_DEPTH(OCTANT_DEPTH)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cw(cw),
    .in_accept(in_accept),
    .restart(restart),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_stall(out_stall),
    .status(status),
    .out_valid(out_valid),
    .point_x(point_x),
    .point_y(point_y),
    .last_point(last_point)
  );

endmodule

`default_nettype wire
